// File: design/assert_macros.svh
// Assertion macros used by the top-level design file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked while reset is released.
`define EPT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define EPT_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define EPT_ASSERT(lbl, clk, rst_n, prop)
`define EPT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: design/ept_pkg.sv
// Package with the CORDIC constants and widths of the pose to transform unit.
package ept_pkg;
  localparam int CORDIC_STEPS = 30;
  localparam int XW = 34;
  localparam int ZW = 33;
  localparam logic [31:0] CORDIC_ONE = 32'd652032874;
  localparam logic [31:0] ATAN_TAB [CORDIC_STEPS] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
    32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051,
    32'h00000028, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;
  typedef logic signed [XW-1:0] cordic_xy_t;
  typedef logic signed [ZW-1:0] cordic_z_t;
endpackage

// File: design/ept_stream_if.sv
// Stream interfaces for the pose input and the transform output.
interface ept_in_if #(parameter int AW = 16, parameter int SW = 32) ();
  logic                 valid;
  logic                 ready;
  logic signed [AW-1:0] roll_angle;
  logic signed [AW-1:0] pitch_angle;
  logic signed [AW-1:0] yaw_angle;
  logic signed [SW-1:0] shift_x;
  logic signed [SW-1:0] shift_y;
  logic signed [SW-1:0] shift_z;
  modport source (output valid, roll_angle, pitch_angle, yaw_angle, shift_x, shift_y,
                  shift_z, input ready);
  modport sink (input valid, roll_angle, pitch_angle, yaw_angle, shift_x, shift_y,
                shift_z, output ready);
endinterface

interface ept_out_if #(parameter int CW = 16, parameter int SW = 32) ();
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] r00;
  logic signed [CW-1:0] r01;
  logic signed [CW-1:0] r02;
  logic signed [CW-1:0] r10;
  logic signed [CW-1:0] r11;
  logic signed [CW-1:0] r12;
  logic signed [CW-1:0] r20;
  logic signed [CW-1:0] r21;
  logic signed [CW-1:0] r22;
  logic signed [SW-1:0] out_x;
  logic signed [SW-1:0] out_y;
  logic signed [SW-1:0] out_z;
  modport source (output valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, out_x, out_y,
                  out_z, input ready);
  modport sink (input valid, r00, r01, r02, r10, r11, r12, r20, r21, r22, out_x, out_y,
                out_z, output ready);
endinterface

// File: design/ept_cordic.sv
// Pipelined CORDIC that turns one binary angle into rounded cosine and sine.
module ept_cordic #(
  parameter int AW = 16,
  parameter int CF = 14
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [AW-1:0]        angle,
  output logic signed [CF+1:0] cos_r,
  output logic signed [CF+1:0] sin_r
);
  localparam int N  = ept_pkg::CORDIC_STEPS;
  localparam int XW = ept_pkg::XW;
  localparam int ZW = ept_pkg::ZW;
  localparam int W  = CF + 2;
  localparam logic signed [XW-1:0] LIM = XW'(1) << CF;

  ept_pkg::cordic_xy_t x_r [0:N];
  ept_pkg::cordic_xy_t y_r [0:N];
  ept_pkg::cordic_z_t  z_r [0:N];
  logic [1:0]          q_r [0:N];

  logic [31:0]         ph;
  logic [1:0]          q;
  logic [31:0]         resid;
  ept_pkg::cordic_xy_t cx;
  ept_pkg::cordic_xy_t sy;
  ept_pkg::cordic_xy_t cx_rnd;
  ept_pkg::cordic_xy_t sy_rnd;
  ept_pkg::cordic_xy_t cx_sat;
  ept_pkg::cordic_xy_t sy_sat;
  logic signed [W-1:0] cos_nxt;
  logic signed [W-1:0] sin_nxt;

  always_comb begin
    ph    = {angle, {(32-AW){1'b0}}};
    q     = ph[31:30] + {1'b0, ph[29]};
    resid = ph - {q, 30'd0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= XW'(ept_pkg::CORDIC_ONE);
      y_r[0] <= '0;
      z_r[0] <= ZW'(signed'(resid));
      q_r[0] <= q;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_step
    localparam logic signed [ZW-1:0] AT = ZW'(ept_pkg::ATAN_TAB[i]);
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[i+1] <= q_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - AT;
        end else begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + AT;
        end
      end
    end
  end

  always_comb begin
    case (q_r[N])
      ept_pkg::QUAD_0: begin cx = x_r[N];  sy = y_r[N];  end
      ept_pkg::QUAD_1: begin cx = -y_r[N]; sy = x_r[N];  end
      ept_pkg::QUAD_2: begin cx = -x_r[N]; sy = -y_r[N]; end
      ept_pkg::QUAD_3: begin cx = y_r[N];  sy = -x_r[N]; end
      default:         begin cx = x_r[N];  sy = y_r[N];  end
    endcase
  end

  if (CF < 30) begin : g_rnd
    localparam logic signed [XW-1:0] HALF = XW'(1) << (29 - CF);
    always_comb begin
      cx_rnd = (cx + HALF) >>> (30 - CF);
      sy_rnd = (sy + HALF) >>> (30 - CF);
    end
  end else begin : g_nornd
    always_comb begin
      cx_rnd = cx;
      sy_rnd = sy;
    end
  end

  always_comb begin
    cx_sat  = (cx_rnd > LIM) ? LIM : ((cx_rnd < -LIM) ? -LIM : cx_rnd);
    sy_sat  = (sy_rnd > LIM) ? LIM : ((sy_rnd < -LIM) ? -LIM : sy_rnd);
    cos_nxt = W'(cx_sat);
    sin_nxt = W'(sy_sat);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= cos_nxt;
      sin_r <= sin_nxt;
    end
  end
endmodule

// File: design/ept_matrix.sv
// Four-stage multiply and round pipeline that forms the nine rotation entries.
module ept_matrix #(
  parameter int CF = 14
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [CF+1:0] cr,
  input  logic signed [CF+1:0] sr,
  input  logic signed [CF+1:0] cp,
  input  logic signed [CF+1:0] sp,
  input  logic signed [CF+1:0] cy,
  input  logic signed [CF+1:0] sy,
  output logic signed [CF+1:0] r00_r,
  output logic signed [CF+1:0] r01_r,
  output logic signed [CF+1:0] r02_r,
  output logic signed [CF+1:0] r10_r,
  output logic signed [CF+1:0] r11_r,
  output logic signed [CF+1:0] r12_r,
  output logic signed [CF+1:0] r20_r,
  output logic signed [CF+1:0] r21_r,
  output logic signed [CF+1:0] r22_r
);
  localparam int W  = CF + 2;
  localparam int PW = 2 * W;
  localparam int SW = PW + 1;
  localparam logic signed [SW-1:0] HALF = SW'(1) << (CF - 1);
  localparam logic signed [SW-1:0] LIM  = SW'(1) << CF;

  function automatic logic signed [W-1:0] ent(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] t;
    t = (v + HALF) >>> CF;
    if (t > LIM) t = LIM;
    else if (t < -LIM) t = -LIM;
    return W'(t);
  endfunction

  logic signed [W-1:0]  a_cr_r, a_sr_r, a_cp_r, a_sp_r, a_cy_r, a_sy_r;
  logic signed [PW-1:0] a_sysp_r, a_cysp_r, a_sycp_r, a_cycp_r;
  logic signed [W-1:0]  b_cr_r, b_sr_r, b_cp_r, b_sp_r, b_cy_r, b_sy_r;
  logic signed [W-1:0]  b_sysp_r, b_cysp_r, b_sycp_r, b_cycp_r;
  logic signed [PW-1:0] c_cpcr_r, c_cpsr_r, c_syspcr_r, c_cysr_r, c_cycr_r, c_sysp_sr_r;
  logic signed [PW-1:0] c_sysr_r, c_cyspcr_r, c_cyspsr_r, c_sycr_r;
  logic signed [W-1:0]  c_sp_r, c_sycp_r, c_cycp_r;

  always_ff @(posedge clk) begin
    if (en) begin
      a_cr_r   <= cr;
      a_sr_r   <= sr;
      a_cp_r   <= cp;
      a_sp_r   <= sp;
      a_cy_r   <= cy;
      a_sy_r   <= sy;
      a_sysp_r <= sy * sp;
      a_cysp_r <= cy * sp;
      a_sycp_r <= sy * cp;
      a_cycp_r <= cy * cp;

      b_cr_r   <= a_cr_r;
      b_sr_r   <= a_sr_r;
      b_cp_r   <= a_cp_r;
      b_sp_r   <= a_sp_r;
      b_cy_r   <= a_cy_r;
      b_sy_r   <= a_sy_r;
      b_sysp_r <= ent(SW'(a_sysp_r));
      b_cysp_r <= ent(SW'(a_cysp_r));
      b_sycp_r <= ent(SW'(a_sycp_r));
      b_cycp_r <= ent(SW'(a_cycp_r));

      c_cpcr_r    <= b_cp_r * b_cr_r;
      c_cpsr_r    <= b_cp_r * b_sr_r;
      c_syspcr_r  <= b_sysp_r * b_cr_r;
      c_cysr_r    <= b_cy_r * b_sr_r;
      c_cycr_r    <= b_cy_r * b_cr_r;
      c_sysp_sr_r <= b_sysp_r * b_sr_r;
      c_sysr_r    <= b_sy_r * b_sr_r;
      c_cyspcr_r  <= b_cysp_r * b_cr_r;
      c_cyspsr_r  <= b_cysp_r * b_sr_r;
      c_sycr_r    <= b_sy_r * b_cr_r;
      c_sp_r      <= b_sp_r;
      c_sycp_r    <= b_sycp_r;
      c_cycp_r    <= b_cycp_r;

      r00_r <= ent(SW'(c_cpcr_r));
      r01_r <= ent(-SW'(c_cpsr_r));
      r02_r <= c_sp_r;
      r10_r <= ent(SW'(c_syspcr_r) + SW'(c_cysr_r));
      r11_r <= ent(SW'(c_cycr_r) - SW'(c_sysp_sr_r));
      r12_r <= -c_sycp_r;
      r20_r <= ent(SW'(c_sysr_r) - SW'(c_cyspcr_r));
      r21_r <= ent(SW'(c_cyspsr_r) + SW'(c_sycr_r));
      r22_r <= c_cycp_r;
    end
  end
endmodule

// File: design/euler_pose_to_transform_unit.sv
// Top level of the Euler pose to homogeneous transform unit.
// Usage: a pose (three binary angles, full circle 2^ANGLE_WIDTH, and a Q16.16
// translation) enters on in_ch; the three rows of the transform, with rotation
// entries in signed fixed point of COEF_FRAC fraction bits and the translation
// passed through, leave on out_ch. Each pose yields exactly one result.
// The pipeline holds 36 register stages: one phase stage, 30 CORDIC iteration
// stages, one rounding stage and four matrix stages, the last of which is the
// output register. Throughput is one pose per cycle unless the receiver
// stalls; the three angles run through three CORDIC pipelines side by side
// and all stages advance together.
// When the receiver stalls with a result waiting, the whole pipeline holds and
// in_ch.ready drops; no transfer is lost or repeated.
// Reset clears every valid bit; data registers are not reset.
`include "assert_macros.svh"
module euler_pose_to_transform_unit #(
  parameter int ANGLE_WIDTH = 16,
  parameter int COEF_FRAC   = 14,
  parameter int SHIFT_WIDTH = 32
) (
  input logic    clk,
  input logic    rst_n,
  ept_in_if.sink   in_ch,
  ept_out_if.source out_ch
);
  localparam int W   = COEF_FRAC + 2;
  localparam int LAT = ept_pkg::CORDIC_STEPS + 6;
  localparam logic signed [W-1:0] LIM = W'(1) << COEF_FRAC;

  logic                     en;
  logic [LAT-1:0]           vld_r;
  logic [3*SHIFT_WIDTH-1:0] tr_r [0:LAT-1];
  logic signed [W-1:0]      cr, sr, cp, sp, cy, sy;

  assign en          = !vld_r[LAT-1] || out_ch.ready;
  assign in_ch.ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tr_r[0] <= {in_ch.shift_x, in_ch.shift_y, in_ch.shift_z};
      for (int i = 1; i < LAT; i++) begin
        tr_r[i] <= tr_r[i-1];
      end
    end
  end

  ept_cordic #(.AW(ANGLE_WIDTH), .CF(COEF_FRAC)) u_roll (
    .clk(clk), .en(en), .angle(in_ch.roll_angle), .cos_r(cr), .sin_r(sr)
  );
  ept_cordic #(.AW(ANGLE_WIDTH), .CF(COEF_FRAC)) u_pitch (
    .clk(clk), .en(en), .angle(in_ch.pitch_angle), .cos_r(cp), .sin_r(sp)
  );
  ept_cordic #(.AW(ANGLE_WIDTH), .CF(COEF_FRAC)) u_yaw (
    .clk(clk), .en(en), .angle(in_ch.yaw_angle), .cos_r(cy), .sin_r(sy)
  );

  ept_matrix #(.CF(COEF_FRAC)) u_matrix (
    .clk(clk), .en(en),
    .cr(cr), .sr(sr), .cp(cp), .sp(sp), .cy(cy), .sy(sy),
    .r00_r(out_ch.r00), .r01_r(out_ch.r01), .r02_r(out_ch.r02),
    .r10_r(out_ch.r10), .r11_r(out_ch.r11), .r12_r(out_ch.r12),
    .r20_r(out_ch.r20), .r21_r(out_ch.r21), .r22_r(out_ch.r22)
  );

  assign out_ch.valid = vld_r[LAT-1];
  assign out_ch.out_x = tr_r[LAT-1][3*SHIFT_WIDTH-1:2*SHIFT_WIDTH];
  assign out_ch.out_y = tr_r[LAT-1][2*SHIFT_WIDTH-1:SHIFT_WIDTH];
  assign out_ch.out_z = tr_r[LAT-1][SHIFT_WIDTH-1:0];

  `EPT_ASSERT_ALWAYS(a_rst_clears, clk, !rst_n |=> !out_ch.valid)
  `EPT_ASSERT(a_stall_holds, clk, rst_n, !en |=> $stable(vld_r))
  `EPT_ASSERT(a_r00_range, clk, rst_n, out_ch.valid |-> (out_ch.r00 <= LIM && out_ch.r00 >= -LIM))
  `EPT_ASSERT(a_r11_range, clk, rst_n, out_ch.valid |-> (out_ch.r11 <= LIM && out_ch.r11 >= -LIM))
endmodule
